// ===== rtl/cct_pkg.sv =====
// Shared types, opcodes and lookup functions for the command translator.
// No dependencies; the front, queue, back and top use it by scoped names.
package cct_pkg;

    // Five bytes of a frame; index 0 is the first byte on the wire
    typedef logic [4:0][7:0] cct_frame_t;

    // One queued command: the first frame and what the later frames need
    typedef struct packed {
        logic [1:0]      count;         // frames to emit, 1..3
        logic            to_host;       // first frame goes back to host
        logic            expect_reply;  // first frame wants a radio reply relayed
        cct_frame_t      frame;         // first frame
        logic [3:0][7:0] resend;        // cached main frequency for the resend frame
    } cct_rec_t;

    // Queue fill status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } cct_q_status_t;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QPtrW      = $clog2(QueueDepth);

    // Opcodes common to both dialects
    localparam logic [7:0] OP_RD_MAIN    = 8'h03;
    localparam logic [7:0] OP_RD_SAT_RX  = 8'h13;
    localparam logic [7:0] OP_RD_SAT_TX  = 8'h23;
    localparam logic [7:0] OP_PTT_OFF    = 8'h80;
    localparam logic [7:0] OP_MODE_MAIN  = 8'h07;
    localparam logic [7:0] OP_MODE_RX    = 8'h17;
    localparam logic [7:0] OP_MODE_TX    = 8'h27;
    localparam logic [7:0] OP_PTT_ON     = 8'h08;
    localparam logic [7:0] OP_PTT_OFF2   = 8'h88;
    localparam logic [7:0] OP_MISC_49    = 8'h49;
    localparam logic [7:0] OP_MISC_89    = 8'h89;
    localparam logic [7:0] OP_MISC_F9    = 8'hF9;
    // Dialect A and native
    localparam logic [7:0] OP_STAT_RX    = 8'hE7;
    localparam logic [7:0] OP_STAT_TX    = 8'hF7;
    localparam logic [7:0] OP_POWER_ON   = 8'h00;
    localparam logic [7:0] OP_SET_MAIN   = 8'h01;
    localparam logic [7:0] OP_A_SET_RX   = 8'h11;
    localparam logic [7:0] OP_A_SET_TX   = 8'h21;
    localparam logic [7:0] OP_A_SAT_ON   = 8'h4E;
    localparam logic [7:0] OP_SAT_OFF    = 8'h8E;
    localparam logic [7:0] OP_RPT_SHIFT  = 8'h09;
    localparam logic [7:0] OP_CTCSS_MODE = 8'h0A;
    localparam logic [7:0] OP_A_TONE     = 8'h0B;
    localparam logic [7:0] OP_N_SET_RX   = 8'h1E;
    localparam logic [7:0] OP_N_SET_TX   = 8'h2E;
    localparam logic [7:0] OP_N_SAT_ON   = 8'h0E;
    localparam logic [7:0] OP_N_MISC_4A  = 8'h4A;
    localparam logic [7:0] OP_N_MISC_8A  = 8'h8A;
    localparam logic [7:0] OP_N_TONE     = 8'hFA;

    // Fixed bytes
    localparam logic [7:0] RX_OPCODE_A   = 8'h1E;
    localparam logic [7:0] TX_OPCODE_A   = 8'h2E;
    localparam logic [7:0] SAT_OPCODE_N  = 8'h0E;
    localparam logic [7:0] TONE_OPCODE_N = 8'hFA;
    localparam logic [7:0] CTCSS_ALT     = 8'h2A;
    localparam logic [7:0] TONE_OFFSET   = 8'd26;
    localparam logic [7:0] TONE_COUNT    = 8'd38;
    localparam logic [7:0] FILL_RX_ON    = 8'h40;
    localparam logic [7:0] FILL_TX_ON    = 8'h00;
    localparam logic [7:0] FILL_RX_OFF   = 8'h47;
    localparam logic [7:0] FILL_TX_OFF   = 8'h80;
    localparam logic [7:0] FILL_RESET    = 8'h80;

    localparam cct_frame_t MAIN_RESET  = {8'h08, 8'h00, 8'h00, 8'h50, 8'h14};
    localparam cct_frame_t SAT_RX_RESET = {8'h00, 8'h00, 8'h00, 8'h50, 8'h14};
    localparam cct_frame_t SAT_TX_RESET = {8'h00, 8'h00, 8'h00, 8'h00, 8'h44};
    localparam cct_frame_t INIT_MODE   = {8'h07, 8'h00, 8'h00, 8'h00, 8'h08};

    // 23 cm band: leading BCD byte 0x24..0x30 moves up by 0xA0
    function automatic logic [7:0] shift_23cm(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b > 8'h23 && b < 8'h31)
        begin
            r = b + 8'hA0;
        end
        return r;
    endfunction

    // Radio reports 23 cm as 0xC_; hosts expect 0x2_
    function automatic logic [7:0] fold_23cm(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b[7:4] == 4'hC)
        begin
            r = {4'h2, b[3:0]};
        end
        return r;
    endfunction

    // Tone index to radio tone code
    function automatic logic [7:0] tone_code(input logic [5:0] idx);
        logic [7:0] r;
        unique case (idx)
            6'd0:  r = 8'h1E;  6'd1:  r = 8'h20;  6'd2:  r = 8'h22;  6'd3:  r = 8'h24;
            6'd4:  r = 8'h26;  6'd5:  r = 8'h28;  6'd6:  r = 8'h2A;  6'd7:  r = 8'h2C;
            6'd8:  r = 8'h2E;  6'd9:  r = 8'h30;  6'd10: r = 8'h32;  6'd11: r = 8'h34;
            6'd12: r = 8'h36;  6'd13: r = 8'h38;  6'd14: r = 8'h16;  6'd15: r = 8'h1A;
            6'd16: r = 8'h1F;  6'd17: r = 8'h21;  6'd18: r = 8'h23;  6'd19: r = 8'h25;
            6'd20: r = 8'h27;  6'd21: r = 8'h29;  6'd22: r = 8'h2B;  6'd23: r = 8'h2D;
            6'd24: r = 8'h2F;  6'd25: r = 8'h31;  6'd26: r = 8'h33;  6'd27: r = 8'h35;
            6'd28: r = 8'h37;  6'd29: r = 8'h39;  6'd30: r = 8'h18;  6'd31: r = 8'h1C;
            6'd32: r = 8'h13;  6'd33: r = 8'h15;  6'd34: r = 8'h17;  6'd35: r = 8'h19;
            6'd36: r = 8'h1B;  6'd37: r = 8'h1D;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/cct_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one five-byte command word.
// No dependencies.
interface cct_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] param_byte_0;
    logic [7:0] param_byte_1;
    logic [7:0] param_byte_2;
    logic [7:0] param_byte_3;
    logic [7:0] opcode;

    modport source (
        output valid, param_byte_0, param_byte_1, param_byte_2, param_byte_3, opcode,
        input  ready
    );
    modport sink (
        input  valid, param_byte_0, param_byte_1, param_byte_2, param_byte_3, opcode,
        output ready
    );
endinterface

// ===== rtl/cct_frame_if.sv =====
// Frame channel: valid/ready handshake carrying one emitted five-byte frame word.
// No dependencies.
interface cct_frame_if;
    logic       valid;
    logic       ready;
    logic       to_host;
    logic [7:0] frame_byte_0;
    logic [7:0] frame_byte_1;
    logic [7:0] frame_byte_2;
    logic [7:0] frame_byte_3;
    logic [7:0] frame_byte_4;
    logic       expect_reply;
    logic       last_frame;

    modport source (
        output valid, to_host, frame_byte_0, frame_byte_1, frame_byte_2,
               frame_byte_3, frame_byte_4, expect_reply, last_frame,
        input  ready
    );
    modport sink (
        input  valid, to_host, frame_byte_0, frame_byte_1, frame_byte_2,
               frame_byte_3, frame_byte_4, expect_reply, last_frame,
        output ready
    );
endinterface

// ===== rtl/cct_front.sv =====
// Front end: accepts commands, decodes both dialects, keeps the caches.
// Depends on cct_pkg and cct_cmd_if; pushes one record per frame-producing command.
module cct_front (
    input  logic                   clk,
    input  logic                   rst_n,
    cct_cmd_if.sink                cmd,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  cct_pkg::cct_q_status_t q_status,
    output logic                   push,
    output cct_pkg::cct_rec_t      rec
);

    logic               host_protocol_reg;
    cct_pkg::cct_frame_t main_reg, main_next;
    cct_pkg::cct_frame_t sat_rx_reg, sat_rx_next;
    cct_pkg::cct_frame_t sat_tx_reg, sat_tx_next;
    logic [7:0]         rx_fill_reg, rx_fill_next;
    logic [7:0]         tx_fill_reg, tx_fill_next;
    cct_pkg::cct_frame_t w;
    logic [5:0]         tone_idx;
    logic               tone_ok;
    logic               accept;

    assign cmd.ready = !q_status.full;
    assign accept    = cmd.valid && cmd.ready;
    assign w = {cmd.opcode, cmd.param_byte_3, cmd.param_byte_2,
                cmd.param_byte_1, cmd.param_byte_0};

    // Tone index: 0..31 direct, 32..63 folded down by 26
    assign tone_ok  = (w[0][7:6] == 2'b00);
    assign tone_idx = (w[0] > 8'd31) ? 6'(w[0] - cct_pkg::TONE_OFFSET) : w[0][5:0];

    // Decode and cache update
    always_comb
    begin
        rec              = '0;
        rec.frame        = w;
        rec.resend       = main_reg[3:0];
        main_next        = main_reg;
        sat_rx_next      = sat_rx_reg;
        sat_tx_next      = sat_tx_reg;
        rx_fill_next     = rx_fill_reg;
        tx_fill_next     = tx_fill_reg;
        unique case (cmd.opcode)
            cct_pkg::OP_RD_MAIN:
            begin
                rec.count = 2'd1; rec.to_host = 1'b1; rec.frame = main_reg;
            end
            cct_pkg::OP_RD_SAT_RX:
            begin
                rec.count = 2'd1; rec.to_host = 1'b1; rec.frame = sat_rx_reg;
            end
            cct_pkg::OP_RD_SAT_TX:
            begin
                rec.count = 2'd1; rec.to_host = 1'b1; rec.frame = sat_tx_reg;
            end
            cct_pkg::OP_MODE_MAIN:
            begin
                rec.count = 2'd1; main_next[4] = w[0];
            end
            cct_pkg::OP_MODE_RX:
            begin
                rec.count = 2'd1; sat_rx_next[4] = w[0];
            end
            cct_pkg::OP_MODE_TX:
            begin
                rec.count = 2'd1; sat_tx_next[4] = w[0];
            end
            cct_pkg::OP_PTT_ON:
            begin
                rec.count = 2'd1;
                rx_fill_next = cct_pkg::FILL_RX_ON;
                tx_fill_next = cct_pkg::FILL_TX_ON;
            end
            cct_pkg::OP_PTT_OFF2:
            begin
                rec.count = 2'd1;
                rx_fill_next = cct_pkg::FILL_RX_OFF;
                tx_fill_next = cct_pkg::FILL_TX_OFF;
            end
            cct_pkg::OP_PTT_OFF, cct_pkg::OP_MISC_49, cct_pkg::OP_MISC_89,
            cct_pkg::OP_MISC_F9:
            begin
                rec.count = 2'd1;
            end
            default:
            begin
                if (host_protocol_reg)
                begin
                    // Native dialect: pass through, fold cached 23 cm codes
                    unique case (cmd.opcode)
                        cct_pkg::OP_STAT_RX, cct_pkg::OP_STAT_TX:
                        begin
                            rec.count = 2'd1; rec.expect_reply = 1'b1;
                        end
                        cct_pkg::OP_SET_MAIN:
                        begin
                            rec.count = 2'd1;
                            main_next[3:0] = {w[3], w[2], w[1], cct_pkg::fold_23cm(w[0])};
                        end
                        cct_pkg::OP_N_SET_RX:
                        begin
                            rec.count = 2'd1;
                            sat_rx_next[3:0] = {w[3], w[2], w[1], cct_pkg::fold_23cm(w[0])};
                        end
                        cct_pkg::OP_N_SET_TX:
                        begin
                            rec.count = 2'd1;
                            sat_tx_next[3:0] = {w[3], w[2], w[1], cct_pkg::fold_23cm(w[0])};
                        end
                        cct_pkg::OP_POWER_ON, cct_pkg::OP_N_SAT_ON, cct_pkg::OP_SAT_OFF,
                        cct_pkg::OP_RPT_SHIFT, cct_pkg::OP_CTCSS_MODE, cct_pkg::OP_N_MISC_4A,
                        cct_pkg::OP_N_MISC_8A, cct_pkg::OP_N_TONE:
                        begin
                            rec.count = 2'd1;
                        end
                        default:
                        begin
                            rec.count = 2'd0;
                        end
                    endcase
                end
                else
                begin
                    // Dialect A
                    unique case (cmd.opcode)
                        cct_pkg::OP_STAT_RX:
                        begin
                            rec.count = 2'd1; rec.to_host = 1'b1;
                            rec.frame = {cct_pkg::OP_STAT_RX, {4{rx_fill_reg}}};
                        end
                        cct_pkg::OP_STAT_TX:
                        begin
                            rec.count = 2'd1; rec.to_host = 1'b1;
                            rec.frame = {cct_pkg::OP_STAT_TX, {4{tx_fill_reg}}};
                        end
                        cct_pkg::OP_POWER_ON:
                        begin
                            rec.count = 2'd3;
                        end
                        cct_pkg::OP_SET_MAIN:
                        begin
                            rec.count = 2'd1;
                            main_next[3:0] = w[3:0];
                            rec.frame[0] = cct_pkg::shift_23cm(w[0]);
                        end
                        cct_pkg::OP_A_SET_RX:
                        begin
                            rec.count = 2'd1;
                            sat_rx_next[3:0] = w[3:0];
                            rec.frame[0] = cct_pkg::shift_23cm(w[0]);
                            rec.frame[4] = cct_pkg::RX_OPCODE_A;
                        end
                        cct_pkg::OP_A_SET_TX:
                        begin
                            rec.count = 2'd1;
                            sat_tx_next[3:0] = w[3:0];
                            rec.frame[0] = cct_pkg::shift_23cm(w[0]);
                            rec.frame[4] = cct_pkg::TX_OPCODE_A;
                        end
                        cct_pkg::OP_A_SAT_ON:
                        begin
                            rec.count = 2'd1; rec.frame[4] = cct_pkg::SAT_OPCODE_N;
                        end
                        cct_pkg::OP_SAT_OFF:
                        begin
                            rec.count = 2'd2;
                        end
                        cct_pkg::OP_RPT_SHIFT:
                        begin
                            rec.count = 2'd1; rec.frame[4] = w[0];
                        end
                        cct_pkg::OP_CTCSS_MODE:
                        begin
                            // parameter equal to the opcode itself is dropped
                            if (w[0] == cct_pkg::OP_CTCSS_MODE)
                            begin
                                rec.count = 2'd0;
                            end
                            else
                            begin
                                rec.count = 2'd1;
                                rec.frame[4] = (w[0] == cct_pkg::CTCSS_ALT) ?
                                               cct_pkg::OP_CTCSS_MODE : w[0];
                            end
                        end
                        cct_pkg::OP_A_TONE:
                        begin
                            if (tone_ok)
                            begin
                                rec.count = 2'd1;
                                rec.frame[0] = cct_pkg::tone_code(tone_idx);
                                rec.frame[4] = cct_pkg::TONE_OPCODE_N;
                            end
                            else
                            begin
                                rec.count = 2'd0;
                            end
                        end
                        default:
                        begin
                            rec.count = 2'd0;
                        end
                    endcase
                end
            end
        endcase
    end

    assign push = accept && (rec.count != 2'd0);

    // Cache and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_protocol_reg <= 1'b0;
            main_reg          <= cct_pkg::MAIN_RESET;
            sat_rx_reg        <= cct_pkg::SAT_RX_RESET;
            sat_tx_reg        <= cct_pkg::SAT_TX_RESET;
            rx_fill_reg       <= cct_pkg::FILL_RESET;
            tx_fill_reg       <= cct_pkg::FILL_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                host_protocol_reg <= cfg_wdata;
            end
            if (accept)
            begin
                main_reg    <= main_next;
                sat_rx_reg  <= sat_rx_next;
                sat_tx_reg  <= sat_tx_next;
                rx_fill_reg <= rx_fill_next;
                tx_fill_reg <= tx_fill_next;
            end
        end
    end

endmodule

// ===== rtl/cct_queue.sv =====
// Short record queue between decode and frame emission.
// Depends on cct_pkg for the record and status types.
module cct_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cct_pkg::cct_rec_t      push_rec,
    input  logic                   pop,
    output cct_pkg::cct_rec_t      head,
    output cct_pkg::cct_q_status_t status
);

    localparam int unsigned CntW = $clog2(cct_pkg::QueueDepth + 1);

    cct_pkg::cct_rec_t            entry_reg [cct_pkg::QueueDepth];
    logic [cct_pkg::QPtrW-1:0]    wr_ptr_reg;
    logic [cct_pkg::QPtrW-1:0]    rd_ptr_reg;
    logic [CntW-1:0]              count_reg;

    assign status.full  = (count_reg == CntW'(cct_pkg::QueueDepth));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= cct_pkg::QPtrW'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= cct_pkg::QPtrW'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                count_reg <= CntW'(count_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                count_reg <= CntW'(count_reg - 1'b1);
            end
        end
    end

endmodule

// ===== rtl/cct_back.sv =====
// Back end: expands the queue head into one to three frames, one per cycle while frm is ready.
// Depends on cct_pkg and cct_frame_if.
module cct_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cct_pkg::cct_rec_t      head,
    input  cct_pkg::cct_q_status_t q_status,
    output logic                   pop,
    cct_frame_if.source            frm
);

    logic [1:0]          idx_reg;
    logic                last;
    logic                fire;
    cct_pkg::cct_frame_t sel;
    logic                sel_host;
    logic                sel_reply;

    // Frame select: first frame, main resend, then init mode
    always_comb
    begin
        sel       = head.frame;
        sel_host  = head.to_host;
        sel_reply = head.expect_reply;
        unique case (idx_reg)
            2'd1:
            begin
                sel       = {cct_pkg::OP_SET_MAIN, head.resend};
                sel_host  = 1'b0;
                sel_reply = 1'b0;
            end
            2'd2:
            begin
                sel       = cct_pkg::INIT_MODE;
                sel_host  = 1'b0;
                sel_reply = 1'b0;
            end
            default:
            begin
                sel       = head.frame;
                sel_host  = head.to_host;
                sel_reply = head.expect_reply;
            end
        endcase
    end

    assign last = (idx_reg == 2'(head.count - 2'd1));
    assign fire = frm.valid && frm.ready;
    assign pop  = fire && last;

    assign frm.valid        = !q_status.empty;
    assign frm.to_host      = sel_host;
    assign frm.frame_byte_0 = sel[0];
    assign frm.frame_byte_1 = sel[1];
    assign frm.frame_byte_2 = sel[2];
    assign frm.frame_byte_3 = sel[3];
    assign frm.frame_byte_4 = sel[4];
    assign frm.expect_reply = sel_reply;
    assign frm.last_frame   = last;

    // Frame index within the current record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else if (fire)
        begin
            idx_reg <= last ? 2'd0 : 2'(idx_reg + 2'd1);
        end
    end

endmodule

// ===== rtl/cat_command_translator.sv =====
// Radio control command translator, top level.
// Depends on cct_pkg, cct_cmd_if, cct_frame_if, cct_front, cct_queue, cct_back.
//
// Usage:
//   cmd  : command words in (four parameter bytes and an opcode), valid/ready.
//   frm  : frame words out, valid/ready; each carries to_host, five bytes,
//          expect_reply, and last_frame on the final frame of a command.
//   cfg_we/cfg_wdata : host_protocol, 0 = dialect A, 1 = native pass-through.
// A command is decoded in the cycle it is accepted; caches update then.
// Commands that produce frames enter a two-entry record queue; unknown
// opcodes produce nothing and leave no trace.
// A command's first frame is offered once its record reaches the queue head.
// Output: one frame per cycle while frm.ready is high, one to three frames per
// command as set by its frame count; input accepts one word per cycle while the
// queue has room.
// Reset: caches load their power-on values (145 MHz FM main, fills 0x80),
// queue empties, dialect A selected.
// Output stall: frames hold; input keeps accepting until the queue fills.
module cat_command_translator (
    input  logic        clk,
    input  logic        rst_n,
    cct_cmd_if.sink     cmd,
    cct_frame_if.source frm,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    cct_pkg::cct_rec_t      push_rec;
    cct_pkg::cct_rec_t      head;
    cct_pkg::cct_q_status_t q_status;
    logic                   push;
    logic                   pop;

    cct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .q_status (q_status),
        .push     (push),
        .rec      (push_rec)
    );

    cct_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_rec(push_rec),
        .pop     (pop),
        .head    (head),
        .status  (q_status)
    );

    cct_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_status(q_status),
        .pop     (pop),
        .frm     (frm)
    );

endmodule
